FILE: rtl/smsa_pkg.sv
package smsa_pkg;

   typedef enum logic [7:0] {
      ST_CLEAR  = 8'b0000_0001,
      ST_IDLE   = 8'b0000_0010,
      ST_SCAN   = 8'b0000_0100,
      ST_DEC_RD = 8'b0000_1000,
      ST_DEC_WR = 8'b0001_0000,
      ST_INC_RD = 8'b0010_0000,
      ST_INC_WR = 8'b0100_0000,
      ST_PUSH   = 8'b1000_0000
   } state_type;

   localparam int unsigned CFG_LEN_W  = 11;
   localparam int unsigned SAMPLE_W   = 8;
   localparam int unsigned MEDIAN_W   = 9;
   localparam int unsigned COUNT_W    = 32;
   localparam int unsigned LEN_RESET  = 1;

endpackage

FILE: rtl/sliding_median_spike_alert.sv
// Channel | Direction | Handshake             | Payload
// csr     | in        | csr_valid / csr_ready | csr_window_len [10:0]
// req     | in        | req_valid / req_ready | req_sample [7:0]
// rsp     | out       | rsp_valid / rsp_ready | rsp_alert, rsp_median_doubled [8:0],
//         |           |                       | rsp_alert_count [31:0]
//
// A filling item steps through INC_RD and INC_WR; a full-window item runs SCAN, DEC_RD, DEC_WR,
// INC_RD, INC_WR and PUSH, and its median scan reads one histogram bin per cycle until the upper
// middle rank is reached. After reset and after every csr write the histogram is cleared,
// during which req_ready is low; csr writes are always taken.
// A result waits in the output register; a stalled rsp side holds the next item
// in its final step.
module sliding_median_spike_alert #(
   parameter int unsigned NUM_BINS   = 256,
   parameter int unsigned WINDOW_MAX = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [smsa_pkg::CFG_LEN_W-1:0]   csr_window_len,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [smsa_pkg::SAMPLE_W-1:0]    req_sample,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_alert,
   output logic [smsa_pkg::MEDIAN_W-1:0]    rsp_median_doubled,
   output logic [smsa_pkg::COUNT_W-1:0]     rsp_alert_count
);
   import smsa_pkg::*;

   localparam int unsigned BIN_W  = $clog2(NUM_BINS);
   localparam int unsigned LEN_W  = $clog2(WINDOW_MAX + 1);
   localparam int unsigned ADDR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int unsigned MD_W   = BIN_W + 1;
   localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(NUM_BINS - 1);

   logic [LEN_W-1:0] hist_mem [NUM_BINS];
   logic [BIN_W-1:0] win_mem  [WINDOW_MAX];

   state_type              state_ff, state_in;
   logic [CFG_LEN_W-1:0]   wlen_ff, wlen_in;
   logic [ADDR_W-1:0]      wptr_ff, wptr_in;
   logic [LEN_W-1:0]       fill_ff, fill_in;
   logic [COUNT_W-1:0]     total_ff, total_in;
   logic [BIN_W-1:0]       clr_ff, clr_in;
   logic [BIN_W-1:0]       scan_ff, scan_in;
   logic [BIN_W-1:0]       bin_d_ff, bin_d_in;
   logic                   dvld_ff, dvld_in;
   logic [LEN_W-1:0]       run_ff, run_in;
   logic                   found1_ff, found1_in;
   logic [BIN_W-1:0]       m1_ff, m1_in;
   logic                   filling_ff, filling_in;
   logic [BIN_W-1:0]       sample_ff, sample_in;
   logic [ADDR_W-1:0]      slot_ff, slot_in;
   logic [MD_W-1:0]        mdbl_ff, mdbl_in;
   logic                   alert_ff, alert_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   out_alert_ff, out_alert_in;
   logic [MEDIAN_W-1:0]    out_md_ff, out_md_in;
   logic [COUNT_W-1:0]     out_cnt_ff, out_cnt_in;

   logic [LEN_W-1:0]       hist_rd_ff;
   logic [BIN_W-1:0]       old_ff;

   logic                   hist_we;
   logic [BIN_W-1:0]       hist_wa;
   logic [LEN_W-1:0]       hist_wd;
   logic [BIN_W-1:0]       hist_ra;
   logic                   win_we;

   logic [31:0]            wl32, len32;
   logic [LEN_W-1:0]       len, rank1, rank2, run_sum;
   logic                   hit1, hit2, scan_done;
   logic [BIN_W-1:0]       m1_fin, m2_fin, clamp_s;
   logic [31:0]            md32;
   logic                   req_take, out_free;

   assign wl32  = 32'(wlen_ff);
   assign len32 = (wl32 == 32'd0) ? 32'd1 :
                  (wl32 > 32'(WINDOW_MAX)) ? 32'(WINDOW_MAX) : wl32;
   assign len   = LEN_W'(len32);
   assign rank1 = LEN_W'((len32 + 32'd1) >> 1);
   assign rank2 = LEN_W'((len32 >> 1) + 32'd1);

   assign run_sum   = run_ff + hist_rd_ff;
   assign hit1      = run_sum >= rank1;
   assign hit2      = run_sum >= rank2;
   assign scan_done = dvld_ff && (hit2 || (bin_d_ff == LAST_BIN));
   assign m1_fin    = found1_ff ? m1_ff : (hit1 ? bin_d_ff : LAST_BIN);
   assign m2_fin    = hit2 ? bin_d_ff : LAST_BIN;

   assign clamp_s   = (32'(req_sample) >= 32'(NUM_BINS)) ? LAST_BIN : BIN_W'(req_sample);
   assign md32      = 32'(mdbl_ff);

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign csr_ready = 1'b1;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_alert          = out_alert_ff;
   assign rsp_median_doubled = out_md_ff;
   assign rsp_alert_count    = out_cnt_ff;

   always_comb begin
      state_in     = state_ff;
      wlen_in      = wlen_ff;
      wptr_in      = wptr_ff;
      fill_in      = fill_ff;
      total_in     = total_ff;
      clr_in       = clr_ff;
      scan_in      = scan_ff;
      bin_d_in     = scan_ff;
      dvld_in      = 1'b0;
      run_in       = run_ff;
      found1_in    = found1_ff;
      m1_in        = m1_ff;
      filling_in   = filling_ff;
      sample_in    = sample_ff;
      slot_in      = slot_ff;
      mdbl_in      = mdbl_ff;
      alert_in     = alert_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      out_alert_in = out_alert_ff;
      out_md_in    = out_md_ff;
      out_cnt_in   = out_cnt_ff;
      hist_we      = 1'b0;
      hist_wa      = clr_ff;
      hist_wd      = '0;
      hist_ra      = scan_ff;
      win_we       = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            hist_we = 1'b1;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == LAST_BIN) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               sample_in  = clamp_s;
               slot_in    = (32'(wptr_ff) >= len32) ? '0 : wptr_ff;
               filling_in = fill_ff < len;
               scan_in    = '0;
               run_in     = '0;
               found1_in  = 1'b0;
               state_in   = (fill_ff < len) ? ST_INC_RD : ST_SCAN;
            end
         end
         ST_SCAN: begin
            hist_ra = scan_ff;
            if (scan_ff != LAST_BIN) begin
               scan_in = scan_ff + 1'b1;
            end
            dvld_in = !scan_done;
            if (dvld_ff) begin
               run_in = run_sum;
               if (!found1_ff && hit1) begin
                  found1_in = 1'b1;
                  m1_in     = bin_d_ff;
               end
            end
            if (scan_done) begin
               mdbl_in  = MD_W'(m1_fin) + MD_W'(m2_fin);
               state_in = ST_DEC_RD;
            end
         end
         ST_DEC_RD: begin
            hist_ra  = old_ff;
            alert_in = MD_W'(sample_ff) >= mdbl_ff;
            if ((MD_W'(sample_ff) >= mdbl_ff) && (total_ff != '1)) begin
               total_in = total_ff + 1'b1;
            end
            state_in = ST_DEC_WR;
         end
         ST_DEC_WR: begin
            hist_wa  = old_ff;
            hist_wd  = hist_rd_ff - 1'b1;
            hist_we  = hist_rd_ff != '0;
            state_in = ST_INC_RD;
         end
         ST_INC_RD: begin
            hist_ra  = sample_ff;
            state_in = ST_INC_WR;
         end
         ST_INC_WR: begin
            hist_wa  = sample_ff;
            hist_wd  = hist_rd_ff + 1'b1;
            hist_we  = 1'b1;
            win_we   = 1'b1;
            wptr_in  = ((32'(slot_ff) + 32'd1) >= len32) ? '0 : (slot_ff + 1'b1);
            if (filling_ff) begin
               fill_in  = fill_ff + 1'b1;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_alert_in = alert_ff;
               out_md_in    = md32[MEDIAN_W-1:0];
               out_cnt_in   = total_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase

      if (csr_valid && csr_ready) begin
         wlen_in  = csr_window_len;
         wptr_in  = '0;
         fill_in  = '0;
         clr_in   = '0;
         state_in = ST_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         wlen_ff      <= CFG_LEN_W'(LEN_RESET);
         wptr_ff      <= '0;
         fill_ff      <= '0;
         total_ff     <= '0;
         clr_ff       <= '0;
         dvld_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wlen_ff      <= wlen_in;
         wptr_ff      <= wptr_in;
         fill_ff      <= fill_in;
         total_ff     <= total_in;
         clr_ff       <= clr_in;
         dvld_ff      <= dvld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff      <= scan_in;
      bin_d_ff     <= bin_d_in;
      run_ff       <= run_in;
      found1_ff    <= found1_in;
      m1_ff        <= m1_in;
      filling_ff   <= filling_in;
      sample_ff    <= sample_in;
      slot_ff      <= slot_in;
      mdbl_ff      <= mdbl_in;
      alert_ff     <= alert_in;
      out_alert_ff <= out_alert_in;
      out_md_ff    <= out_md_in;
      out_cnt_ff   <= out_cnt_in;
   end

   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[hist_wa] <= hist_wd;
      end
      hist_rd_ff <= hist_mem[hist_ra];
   end

   always_ff @(posedge clock) begin
      if (win_we) begin
         win_mem[slot_ff] <= sample_ff;
      end
      old_ff <= win_mem[slot_ff];
   end

endmodule

FILE: tb/smsa_spike_checker.sv
module smsa_spike_checker #(
   parameter int unsigned NUM_BINS   = 256,
   parameter int unsigned WINDOW_MAX = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [smsa_pkg::CFG_LEN_W-1:0]    csr_window_len,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic [smsa_pkg::SAMPLE_W-1:0]     req_sample,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic                              rsp_alert,
   input  logic [smsa_pkg::MEDIAN_W-1:0]     rsp_median_doubled,
   input  logic [smsa_pkg::COUNT_W-1:0]      rsp_alert_count,
   output int unsigned                       fail_count,
   output int unsigned                       results_owed
);

   localparam int unsigned BIN_W  = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
   localparam int unsigned SLOT_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

   typedef struct packed {
      logic                            alert;
      logic [smsa_pkg::MEDIAN_W-1:0]   median_doubled;
      logic [smsa_pkg::COUNT_W-1:0]    alert_count;
   } spike_result_type;

   logic [smsa_pkg::CFG_LEN_W-1:0]  len_setting;
   logic [smsa_pkg::CFG_LEN_W-1:0]  bin_tally [NUM_BINS];
   logic [smsa_pkg::SAMPLE_W-1:0]   window_line [WINDOW_MAX];
   logic [SLOT_W-1:0]               oldest_slot;
   logic [smsa_pkg::CFG_LEN_W-1:0]  taken_in;
   logic [smsa_pkg::COUNT_W-1:0]    alerts_seen;
   spike_result_type                spike_due [$];
   int unsigned                     fails = 0;

   task automatic report_mismatch(input string note);
      $display("mismatch at %0t: %s", $realtime, note);
      fails++;
   endtask

   task automatic clear_window();
      for (int unsigned b = 0; b < NUM_BINS; b++) bin_tally[b[BIN_W-1:0]] = '0;
      oldest_slot = '0;
      taken_in    = '0;
   endtask

   function automatic int unsigned bin_at_rank(input int unsigned rank);
      int unsigned run;
      run = 0;
      for (int unsigned b = 0; b < NUM_BINS; b++) begin
         run += 32'(bin_tally[b[BIN_W-1:0]]);
         if (run >= rank) return b;
      end
      return NUM_BINS - 1;
   endfunction

   task automatic absorb_sample(input logic [smsa_pkg::SAMPLE_W-1:0] s);
      int unsigned span;
      int unsigned slot;
      int unsigned bin;
      int unsigned old;
      int unsigned twice_med;
      int unsigned next_slot;
      spike_result_type r;
      if (len_setting == '0) span = 1;
      else if (32'(len_setting) > WINDOW_MAX) span = WINDOW_MAX;
      else span = 32'(len_setting);
      bin  = (32'(s) >= NUM_BINS) ? NUM_BINS - 1 : 32'(s);
      slot = (32'(oldest_slot) >= span) ? 0 : 32'(oldest_slot);
      if (32'(taken_in) < span) begin
         window_line[slot[SLOT_W-1:0]] = bin[smsa_pkg::SAMPLE_W-1:0];
         bin_tally[bin[BIN_W-1:0]]     = bin_tally[bin[BIN_W-1:0]] + 1'b1;
         taken_in                      = taken_in + 1'b1;
      end else begin
         twice_med = bin_at_rank((span + 1) / 2) + bin_at_rank(span / 2 + 1);
         r.alert   = (bin >= twice_med);
         if (r.alert && alerts_seen != '1) alerts_seen = alerts_seen + 1'b1;
         r.median_doubled = twice_med[smsa_pkg::MEDIAN_W-1:0];
         r.alert_count    = alerts_seen;
         spike_due        = {spike_due, r};
         // retire the oldest item, then enter the new one
         old = 32'(window_line[slot[SLOT_W-1:0]]);
         if (old >= NUM_BINS) old = NUM_BINS - 1;
         if (bin_tally[old[BIN_W-1:0]] != '0)
            bin_tally[old[BIN_W-1:0]] = bin_tally[old[BIN_W-1:0]] - 1'b1;
         bin_tally[bin[BIN_W-1:0]]     = bin_tally[bin[BIN_W-1:0]] + 1'b1;
         window_line[slot[SLOT_W-1:0]] = bin[smsa_pkg::SAMPLE_W-1:0];
      end
      next_slot   = (slot + 1 >= span) ? 0 : slot + 1;
      oldest_slot = next_slot[SLOT_W-1:0];
   endtask

   always @(posedge clock) begin
      spike_result_type want;
      if (reset) begin
         len_setting = smsa_pkg::LEN_RESET;
         alerts_seen = '0;
         clear_window();
         spike_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (spike_due.size() == 0) begin
               report_mismatch($sformatf("result with nothing expected (median_doubled %0d)",
                                         rsp_median_doubled));
            end else begin
               want = spike_due.pop_front();
               if (rsp_alert !== want.alert)
                  report_mismatch($sformatf("alert %0b, expected %0b",
                                            rsp_alert, want.alert));
               if (rsp_median_doubled !== want.median_doubled)
                  report_mismatch($sformatf("median_doubled %0d, expected %0d",
                                            rsp_median_doubled, want.median_doubled));
               if (rsp_alert_count !== want.alert_count)
                  report_mismatch($sformatf("alert_count %0d, expected %0d",
                                            rsp_alert_count, want.alert_count));
            end
         end
         if (csr_valid && csr_ready) begin
            len_setting = csr_window_len;
            clear_window();
         end
         if (req_valid && req_ready) absorb_sample(req_sample);
      end
      fail_count   <= fails;
      results_owed <= spike_due.size();
   end

endmodule

FILE: tb/tb_sliding_median_spike_alert.sv
module tb_sliding_median_spike_alert;

   import smsa_pkg::*;

   localparam int unsigned NUM_BINS      = 256;
   localparam int unsigned WINDOW_MAX    = 1024;
   localparam int unsigned SETTLE        = NUM_BINS + 40;
   localparam int unsigned CYCLE_LIMIT   = 3_000_000;
   localparam int unsigned IDLE_PCT      = 23;
   localparam int unsigned ITEM_TARGET   = 800;

   logic                   clock;
   logic                   reset;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CFG_LEN_W-1:0]   csr_window_len;
   logic                   req_valid;
   logic                   req_ready;
   logic [SAMPLE_W-1:0]    req_sample;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic                   rsp_alert;
   logic [MEDIAN_W-1:0]    rsp_median_doubled;
   logic [COUNT_W-1:0]     rsp_alert_count;

   int unsigned            fail_count;
   int unsigned            results_owed;
   int unsigned            cycle_count = 0;
   int unsigned            items_sent = 0;
   int unsigned            phase_index = 0;
   logic                   calm = 1'b0;

   logic [SAMPLE_W-1:0] directed_samples [21] = '{
      8'd0, 8'd0, 8'd255, 8'd255, 8'd0, 8'd128, 8'd127,
      8'd5, 8'd10, 8'd20, 8'd9,
      8'd4, 8'd6, 8'd10, 8'd5, 8'd255,
      8'd7, 8'd1, 8'd200, 8'd14, 8'd3
   };

   sliding_median_spike_alert #(
      .NUM_BINS   (NUM_BINS),
      .WINDOW_MAX (WINDOW_MAX)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_window_len     (csr_window_len),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_sample         (req_sample),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_alert          (rsp_alert),
      .rsp_median_doubled (rsp_median_doubled),
      .rsp_alert_count    (rsp_alert_count)
   );

   smsa_spike_checker #(
      .NUM_BINS   (NUM_BINS),
      .WINDOW_MAX (WINDOW_MAX)
   ) spike_checker (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_window_len     (csr_window_len),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_sample         (req_sample),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_alert          (rsp_alert),
      .rsp_median_doubled (rsp_median_doubled),
      .rsp_alert_count    (rsp_alert_count),
      .fail_count         (fail_count),
      .results_owed       (results_owed)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic send_sample(input logic [SAMPLE_W-1:0] s);
      if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         do @(negedge clock); while (!calm && $urandom_range(0, 99) < IDLE_PCT);
      end
      req_valid  <= 1'b1;
      req_sample <= s;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (results_owed != 0) @(negedge clock);
   endtask

   task automatic write_window(input logic [CFG_LEN_W-1:0] len_code);
      drain_results();
      // let a filling item finish before the write
      repeat (SETTLE) @(negedge clock);
      csr_valid      <= 1'b1;
      csr_window_len <= len_code;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_sample(input int unsigned base);
      int unsigned v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: v = base + $urandom_range(0, 8);
         4, 5:       v = 2 * base + $urandom_range(0, 40);
         6:          v = (base > 0) ? 2 * base - 1 : 0;
         7:          v = $urandom_range(0, 1) ? 255 : 0;
         default:    v = $urandom_range(0, 255);
      endcase
      if (v > 255) v = 255;
      return v[SAMPLE_W-1:0];
   endfunction

   task automatic run_phase(input logic [CFG_LEN_W-1:0] len_code, input int unsigned results);
      int unsigned span;
      int unsigned base;
      int unsigned hold_at;
      write_window(len_code);
      if (len_code == '0) span = 1;
      else if (32'(len_code) > WINDOW_MAX) span = WINDOW_MAX;
      else span = 32'(len_code);
      base    = $urandom_range(0, 120);
      hold_at = span + $urandom_range(0, results - 1);
      calm   <= (phase_index == 1);
      for (int unsigned i = 0; i < span + results; i++) begin
         if (i == hold_at) drain_results();
         send_sample(pick_sample(base));
      end
      phase_index++;
   endtask

   initial begin
      logic [CFG_LEN_W-1:0] len_code;
      reset          = 1'b1;
      csr_valid      = 1'b0;
      csr_window_len = '0;
      req_valid      = 1'b0;
      req_sample     = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_samples[i]) begin
         if (i == 7) write_window(11'd0);
         if (i == 11) write_window(11'd2);
         if (i == 16) write_window(11'd3);
         send_sample(directed_samples[i]);
      end

      while (items_sent < ITEM_TARGET) begin
         case ($urandom_range(0, 9))
            0:             len_code = CFG_LEN_W'($urandom_range(0, 2));
            1, 2, 3, 4, 5: len_code = CFG_LEN_W'($urandom_range(3, 16));
            6, 7, 8:       len_code = CFG_LEN_W'($urandom_range(17, 64));
            default:       len_code = CFG_LEN_W'($urandom_range(65, 160));
         endcase
         begin
            int unsigned results;
            results = $urandom_range(15, 45);
            run_phase(len_code, results);
         end
      end

      drain_results();
      repeat (SETTLE) @(negedge clock);
      if (fail_count == 0 && results_owed == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

FILE: sliding_median_spike_alert.f
rtl/smsa_pkg.sv
rtl/sliding_median_spike_alert.sv
tb/smsa_spike_checker.sv
tb/tb_sliding_median_spike_alert.sv
